@@ rtl/core/grid_ray_cell_walk_defines.svh @@
// assertion macros for the ray cell walker
`ifndef GRID_RAY_CELL_WALK_DEFINES_SVH
`define GRID_RAY_CELL_WALK_DEFINES_SVH

// same-cycle implication
`define GRCW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GRCW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/grcw_pkg.sv @@
`timescale 1ns / 1ps
package grcw_pkg;
	localparam int IN_W = 24;
	localparam int ABS_W = 24;
	localparam int CELL_W = 13;
	localparam int DIST_W = 25;
	localparam int LEN_W = 25;
	localparam int MUL_W = 25;
	localparam int PROD_W = 50;
	localparam int REM_W = 28;
	localparam int MAX_CELLS_DEF = 64;
	localparam int FRAC_BITS_DEF = 12;

	typedef enum logic {
		OP_DIV = 1'b0,
		OP_SQRT = 1'b1
	} ds_op_t;

	typedef struct packed {
		logic start;
		ds_op_t op;
		logic [PROD_W-1:0] num;
		logic [LEN_W-1:0] den;
	} ds_req_t;

	typedef struct packed {
		logic done;
		logic [PROD_W-1:0] quo;
		logic [REM_W-1:0] rem;
	} ds_rsp_t;
endpackage

@@ rtl/core/grcw_ray_if.sv @@
`timescale 1ns / 1ps
interface grcw_ray_if;
	logic valid;
	logic ready;
	logic signed [grcw_pkg::IN_W-1:0] begin_x;
	logic signed [grcw_pkg::IN_W-1:0] begin_y;
	logic signed [grcw_pkg::IN_W-1:0] begin_z;
	logic signed [grcw_pkg::IN_W-1:0] end_x;
	logic signed [grcw_pkg::IN_W-1:0] end_y;
	logic signed [grcw_pkg::IN_W-1:0] end_z;

	modport source (output valid, begin_x, begin_y, begin_z, end_x, end_y, end_z,
		input ready);
	modport sink (input valid, begin_x, begin_y, begin_z, end_x, end_y, end_z,
		output ready);
endinterface

@@ rtl/core/grcw_hit_if.sv @@
`timescale 1ns / 1ps
interface grcw_hit_if;
	logic valid;
	logic ready;
	logic signed [grcw_pkg::CELL_W-1:0] cell_x;
	logic signed [grcw_pkg::CELL_W-1:0] cell_z;
	logic signed [grcw_pkg::CELL_W-1:0] next_cell_x;
	logic signed [grcw_pkg::CELL_W-1:0] next_cell_z;
	logic [grcw_pkg::DIST_W-1:0] enter_dist;
	logic [grcw_pkg::DIST_W-1:0] exit_dist;
	logic last;
	logic truncated;

	modport source (output valid, cell_x, cell_z, next_cell_x, next_cell_z, enter_dist,
		exit_dist, last, truncated, input ready);
	modport sink (input valid, cell_x, cell_z, next_cell_x, next_cell_z, enter_dist,
		exit_dist, last, truncated, output ready);
endinterface

@@ rtl/core/grcw_mul.sv @@
`timescale 1ns / 1ps
module grcw_mul (
	input  logic clk,
	input  logic [grcw_pkg::MUL_W-1:0] a,
	input  logic [grcw_pkg::MUL_W-1:0] b,
	output logic [grcw_pkg::PROD_W-1:0] p
);
	logic [grcw_pkg::PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule

@@ rtl/core/grcw_divsqrt.sv @@
`timescale 1ns / 1ps
module grcw_divsqrt (
	input  logic clk,
	input  logic arst_n,
	input  grcw_pkg::ds_req_t req,
	output grcw_pkg::ds_rsp_t rsp
);
	localparam int PW = grcw_pkg::PROD_W;
	localparam int RW = grcw_pkg::REM_W;
	localparam int LW = grcw_pkg::LEN_W;
	localparam logic [5:0] DIV_STEPS = 6'(PW);
	localparam logic [5:0] SQRT_STEPS = 6'(PW / 2);

	logic [5:0] cnt_q;
	logic done_q;
	logic sqrt_q;
	logic [PW-1:0] num_q;
	logic [LW-1:0] den_q;
	logic [PW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] rem_sh;
	logic [RW-1:0] sub_b;
	logic [RW:0] diff;
	logic ge;

	always_comb begin
		if (sqrt_q) begin
			rem_sh = {rem_q[RW-3:0], num_q[PW-1:PW-2]};
			sub_b = {1'b0, quo_q[LW-1:0], 2'b01};
		end else begin
			rem_sh = {rem_q[RW-2:0], num_q[PW-1]};
			sub_b = {{(RW-LW){1'b0}}, den_q};
		end
		diff = {1'b0, rem_sh} - {1'b0, sub_b};
		ge = !diff[RW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q <= (req.op == grcw_pkg::OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
			done_q <= (cnt_q == 6'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			sqrt_q <= (req.op == grcw_pkg::OP_SQRT);
			quo_q <= '0;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= sqrt_q ? {num_q[PW-3:0], 2'b00} : {num_q[PW-2:0], 1'b0};
			quo_q <= {quo_q[PW-2:0], ge};
			rem_q <= ge ? diff[RW-1:0] : rem_sh;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
	assign rsp.rem = rem_q;
endmodule

@@ rtl/core/grid_ray_cell_walk.sv @@
`timescale 1ns / 1ps
// the first cell of a ray waits on the length root and the divides, all on the shared
// bit-serial divide/sqrt unit (one 25-step root, four 50-step divides)
// one cell per cycle unless hit stalls, up to MAX_CELLS cells; one ray at a time
// a ray shorter than the epsilon gives no cell and returns to idle from the check
// reset: arst_n clears the sequencer and output valid, the block comes up idle
module grid_ray_cell_walk #(
	parameter int MAX_CELLS = grcw_pkg::MAX_CELLS_DEF,
	parameter int FRAC_BITS = grcw_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	grcw_ray_if.sink ray,
	grcw_hit_if.source hit
);
`include "grid_ray_cell_walk_defines.svh"

	localparam int IW = grcw_pkg::IN_W;
	localparam int AW = grcw_pkg::ABS_W;
	localparam int CW = grcw_pkg::CELL_W;
	localparam int LW = grcw_pkg::LEN_W;
	localparam int PW = grcw_pkg::PROD_W;
	localparam int MW = grcw_pkg::MUL_W;
	localparam int NW = 26;
	localparam int KW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam longint EPS_LIM = ((64'd1 << (2 * FRAC_BITS)) + 64'd99999999) / 64'd100000000;
	localparam logic [PW-1:0] EPS_S = PW'(EPS_LIM);
	localparam logic [NW-1:0] UNIT_N = NW'(1) << FRAC_BITS;
	localparam logic [KW-1:0] LAST_K = KW'(MAX_CELLS - 1);

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_MX   = 18'h00002,
		S_MZ   = 18'h00004,
		S_MY   = 18'h00008,
		S_CHK  = 18'h00010,
		S_WSQ  = 18'h00020,
		S_P1   = 18'h00040,
		S_P2   = 18'h00080,
		S_P3   = 18'h00100,
		S_D1   = 18'h00200,
		S_W1   = 18'h00400,
		S_D2   = 18'h00800,
		S_W2   = 18'h01000,
		S_D3   = 18'h02000,
		S_W3   = 18'h04000,
		S_D4   = 18'h08000,
		S_W4   = 18'h10000,
		S_RUN  = 18'h20000
	} state_t;

	state_t st_q;
	logic signed [IW-1:0] bx_q, bz_q;
	logic [AW-1:0] adx_q, ady_q, adz_q;
	logic xneg_q, zneg_q, xmv_q, zmv_q;
	logic [PW-1:0] sf_q;
	logic [CW-1:0] cx_q, cz_q;
	logic [NW-1:0] nx_q, nz_q;
	logic [PW-1:0] px_q, pz_q;
	logic [LW-1:0] len_q, param_q;
	logic [LW-1:0] qx_q, qsx_q, qz_q, qsz_q;
	logic [AW-1:0] rx_q, rsx_q, rz_q, rsz_q;
	logic [KW-1:0] cnt_q;

	logic out_valid_q;
	logic [CW-1:0] o_cx_q, o_cz_q, o_nx_q, o_nz_q;
	logic [LW-1:0] o_enter_q, o_exit_q;
	logic o_last_q, o_trunc_q;

	logic [MW-1:0] mul_a, mul_b;
	logic [PW-1:0] prod;
	grcw_pkg::ds_req_t ds_req;
	grcw_pkg::ds_rsp_t ds_rsp;

	logic signed [IW:0] dx, dy, dz;
	logic [IW:0] adx_w, ady_w, adz_w;
	logic [PW-1:0] s3;
	logic short3, flat_short, xmv_n, zmv_n, fxz, fzz;
	logic [NW-1:0] fx, fz, nx0, nz0;
	logic signed [IW-1:0] bcx, bcz;
	logic [CW-1:0] cx0, cz0;
	logic [LW-1:0] len_rnd;

	logic emit, use_x, done_x, done_z, e_done, e_trunc, e_last;
	logic [LW-1:0] e_exit;
	logic [CW-1:0] cx_step, cz_step;
	logic [AW:0] rsum_x, rsum_z;
	logic car_x, car_z;

	grcw_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.p(prod)
	);

	grcw_divsqrt u_ds (
		.clk(clk),
		.arst_n(arst_n),
		.req(ds_req),
		.rsp(ds_rsp)
	);

	// front end
	always_comb begin
		dx = {ray.end_x[IW-1], ray.end_x} - {ray.begin_x[IW-1], ray.begin_x};
		dy = {ray.end_y[IW-1], ray.end_y} - {ray.begin_y[IW-1], ray.begin_y};
		dz = {ray.end_z[IW-1], ray.end_z} - {ray.begin_z[IW-1], ray.begin_z};
		adx_w = dx[IW] ? -dx : dx;
		ady_w = dy[IW] ? -dy : dy;
		adz_w = dz[IW] ? -dz : dz;
	end

	// length checks and starting cell
	always_comb begin
		s3 = sf_q + prod;
		short3 = s3 < EPS_S;
		flat_short = sf_q < EPS_S;
		xmv_n = !flat_short && (adx_q != '0);
		zmv_n = !flat_short && (adz_q != '0);
		fx = NW'(bx_q[FRAC_BITS-1:0]);
		fz = NW'(bz_q[FRAC_BITS-1:0]);
		fxz = (fx == '0);
		fzz = (fz == '0);
		bcx = bx_q >>> FRAC_BITS;
		bcz = bz_q >>> FRAC_BITS;
		nx0 = fxz ? UNIT_N : (xneg_q ? fx : UNIT_N - fx);
		nz0 = fzz ? UNIT_N : (zneg_q ? fz : UNIT_N - fz);
		cx0 = bcx[CW-1:0] - CW'(xmv_n && xneg_q && fxz);
		cz0 = bcz[CW-1:0] - CW'(zmv_n && zneg_q && fzz);
		len_rnd = ds_rsp.quo[LW-1:0]
			+ LW'(ds_rsp.rem > grcw_pkg::REM_W'(ds_rsp.quo[LW-1:0]));
	end

	// multiplier operand select
	always_comb begin
		case (st_q)
			S_MX: begin
				mul_a = MW'(adx_q);
				mul_b = MW'(adx_q);
			end
			S_MZ: begin
				mul_a = MW'(adz_q);
				mul_b = MW'(adz_q);
			end
			S_MY: begin
				mul_a = MW'(ady_q);
				mul_b = MW'(ady_q);
			end
			S_P1: begin
				mul_a = nx_q[MW-1:0];
				mul_b = MW'(adz_q);
			end
			S_P2: begin
				mul_a = nz_q[MW-1:0];
				mul_b = MW'(adx_q);
			end
			S_P3: begin
				mul_a = nx_q[MW-1:0];
				mul_b = len_q;
			end
			default: begin
				mul_a = nz_q[MW-1:0];
				mul_b = len_q;
			end
		endcase
	end

	// divide/sqrt requests
	always_comb begin
		ds_req.start = 1'b0;
		ds_req.op = grcw_pkg::OP_DIV;
		ds_req.num = prod;
		ds_req.den = LW'(adx_q);
		case (st_q)
			S_CHK: begin
				ds_req.start = !short3;
				ds_req.op = grcw_pkg::OP_SQRT;
				ds_req.num = sf_q;
			end
			S_D1: begin
				ds_req.start = 1'b1;
			end
			S_D2: begin
				ds_req.start = 1'b1;
				ds_req.num = PW'(len_q) << FRAC_BITS;
			end
			S_D3: begin
				ds_req.start = 1'b1;
				ds_req.den = LW'(adz_q);
			end
			S_D4: begin
				ds_req.start = 1'b1;
				ds_req.num = PW'(len_q) << FRAC_BITS;
				ds_req.den = LW'(adz_q);
			end
			default: begin
				ds_req.start = 1'b0;
			end
		endcase
	end

	// one cell step
	always_comb begin
		emit = (st_q == S_RUN) && (!out_valid_q || hit.ready);
		use_x = xmv_q && (!zmv_q || (px_q < pz_q));
		done_x = nx_q > NW'(adx_q);
		done_z = nz_q > NW'(adz_q);
		rsum_x = {1'b0, rx_q} + {1'b0, rsx_q};
		rsum_z = {1'b0, rz_q} + {1'b0, rsz_q};
		car_x = rsum_x >= {1'b0, adx_q};
		car_z = rsum_z >= {1'b0, adz_q};
		cx_step = xneg_q ? cx_q - CW'(1) : cx_q + CW'(1);
		cz_step = zneg_q ? cz_q - CW'(1) : cz_q + CW'(1);
		if (use_x) begin
			e_done = done_x;
			e_exit = done_x ? len_q : qx_q;
		end else if (zmv_q) begin
			e_done = done_z;
			e_exit = done_z ? len_q : qz_q;
		end else begin
			e_done = 1'b1;
			e_exit = len_q;
		end
		e_trunc = !e_done && (cnt_q == LAST_K);
		e_last = e_done || e_trunc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (hit.ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: if (ray.valid) st_q <= S_MX;
				S_MX:   st_q <= S_MZ;
				S_MZ:   st_q <= S_MY;
				S_MY:   st_q <= S_CHK;
				S_CHK:  st_q <= short3 ? S_IDLE : S_WSQ;
				S_WSQ:  if (ds_rsp.done) st_q <= S_P1;
				S_P1:   st_q <= S_P2;
				S_P2:   st_q <= S_P3;
				S_P3:   st_q <= S_D1;
				S_D1:   st_q <= S_W1;
				S_W1:   if (ds_rsp.done) st_q <= S_D2;
				S_D2:   st_q <= S_W2;
				S_W2:   if (ds_rsp.done) st_q <= S_D3;
				S_D3:   st_q <= S_W3;
				S_W3:   if (ds_rsp.done) st_q <= S_D4;
				S_D4:   st_q <= S_W4;
				S_W4:   if (ds_rsp.done) st_q <= S_RUN;
				S_RUN:  if (emit && e_last) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				bx_q <= ray.begin_x;
				bz_q <= ray.begin_z;
				adx_q <= adx_w[AW-1:0];
				ady_q <= ady_w[AW-1:0];
				adz_q <= adz_w[AW-1:0];
				xneg_q <= dx[IW];
				zneg_q <= dz[IW];
			end
			S_MZ: sf_q <= prod;
			S_MY: sf_q <= sf_q + prod;
			S_CHK: begin
				xmv_q <= xmv_n;
				zmv_q <= zmv_n;
				cx_q <= cx0;
				cz_q <= cz0;
				nx_q <= xmv_n ? nx0 : '0;
				nz_q <= zmv_n ? nz0 : '0;
			end
			S_WSQ: if (ds_rsp.done) len_q <= len_rnd;
			S_P2: px_q <= prod;
			S_P3: pz_q <= prod;
			S_W1: if (ds_rsp.done) begin
				qx_q <= ds_rsp.quo[LW-1:0];
				rx_q <= ds_rsp.rem[AW-1:0];
			end
			S_W2: if (ds_rsp.done) begin
				qsx_q <= ds_rsp.quo[LW-1:0];
				rsx_q <= ds_rsp.rem[AW-1:0];
			end
			S_W3: if (ds_rsp.done) begin
				qz_q <= ds_rsp.quo[LW-1:0];
				rz_q <= ds_rsp.rem[AW-1:0];
			end
			S_W4: if (ds_rsp.done) begin
				qsz_q <= ds_rsp.quo[LW-1:0];
				rsz_q <= ds_rsp.rem[AW-1:0];
				param_q <= '0;
				cnt_q <= '0;
			end
			S_RUN: if (emit) begin
				o_cx_q <= cx_q;
				o_cz_q <= cz_q;
				o_nx_q <= use_x ? cx_step : cx_q;
				o_nz_q <= (!use_x && zmv_q) ? cz_step : cz_q;
				o_enter_q <= param_q;
				o_exit_q <= e_exit;
				o_last_q <= e_last;
				o_trunc_q <= e_trunc;
				param_q <= e_exit;
				cnt_q <= cnt_q + KW'(1);
				if (use_x) begin
					cx_q <= cx_step;
					nx_q <= nx_q + UNIT_N;
					px_q <= px_q + (PW'(adz_q) << FRAC_BITS);
					qx_q <= qx_q + qsx_q + LW'(car_x);
					rx_q <= car_x ? AW'(rsum_x - {1'b0, adx_q}) : rsum_x[AW-1:0];
				end else if (zmv_q) begin
					cz_q <= cz_step;
					nz_q <= nz_q + UNIT_N;
					pz_q <= pz_q + (PW'(adx_q) << FRAC_BITS);
					qz_q <= qz_q + qsz_q + LW'(car_z);
					rz_q <= car_z ? AW'(rsum_z - {1'b0, adz_q}) : rsum_z[AW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign ray.ready = (st_q == S_IDLE);
	assign hit.valid = out_valid_q;
	assign hit.cell_x = o_cx_q;
	assign hit.cell_z = o_cz_q;
	assign hit.next_cell_x = o_nx_q;
	assign hit.next_cell_z = o_nz_q;
	assign hit.enter_dist = o_enter_q;
	assign hit.exit_dist = o_exit_q;
	assign hit.last = o_last_q;
	assign hit.truncated = o_trunc_q;

	`GRCW_ASSERT_IMP(a_trunc_last, hit.valid && hit.truncated, hit.last, "truncated cell without last")
	`GRCW_ASSERT_IMP(a_ds_wait, ds_rsp.done, st_q == S_WSQ || st_q == S_W1 || st_q == S_W2 || st_q == S_W3 || st_q == S_W4, "divide/sqrt result outside a wait state")
	`GRCW_ASSERT_NXT(a_last_idle, emit && e_last, st_q == S_IDLE && out_valid_q, "run did not end after last cell")
endmodule
